// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for dda_line_rasterizer.sv. They assume a clock named aclk
// and an active-low synchronous reset named aresetn in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ddalr_pkg.sv =====
package ddalr_pkg;

    localparam int IN_COORD_W = 13;
    localparam int MAG_W      = 13;
    localparam int COORD_W    = 14;
    localparam int POINTS_W   = 14;
    localparam int COLOR_W    = 24;
    localparam int ADDR_W     = 22;
    localparam int CFG_W      = 12;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 48;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV_X = 3'b010,
        ST_DIV_Y = 3'b100
    } ddalr_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ddalr_div_stat_t;

endpackage

// ===== hw/rtl/dda_line_rasterizer.sv =====
// DDA line rasterizer. A begin transaction (tuser = 0) loads two endpoints
// and a color; a tick transaction (tuser = 1) emits the next point of the
// active line with its clipped frame address, tlast marking the last of
// max(|dx|,|dy|) + 1 points. Ticks are taken at one per cycle while the
// block is idle and the output is not stalled; each one yields its result
// from an output register in the next cycle. A begin of nonzero length
// computes both per-step increments on a single shared restoring divider
// that produces one quotient bit per cycle, so the input is held off from
// the accepted begin until both divisions are done. Ticks while no line is
// active are consumed without a result. Frame registers are to be written
// through the APB port only while the block is idle; it does not enforce this.
`include "assert_macros.svh"

module dda_line_rasterizer #(
    parameter int MAX_DIM   = 2048,
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // start_x[12:0], start_y[25:13], end_x[38:26], end_y[51:39],
    // line_color[75:52], zero padding above.
    input  logic [ddalr_pkg::S_TDATA_W-1:0]     s_tdata,
    // func[0].
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // write_address[21:0], pixel_color[45:22], zero padding above.
    output logic [ddalr_pkg::M_TDATA_W-1:0]     m_tdata,
    // write_enable[0].
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ddalr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ddalr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ddalr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import ddalr_pkg::*;

    localparam int ACC_W  = COORD_W + FRAC_BITS;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int NUM_W  = MAG_W + FRAC_BITS;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);

    // Configuration registers.
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FRAME_WIDTH) begin
                frame_width_reg <= pwdata[CFG_W-1:0];
            end else begin
                frame_height_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? APB_DATA_W'(frame_height_reg)
                                                   : APB_DATA_W'(frame_width_reg);

    // Input fields.
    logic                  s_func;
    logic [IN_COORD_W-1:0] s_start_x, s_start_y, s_end_x, s_end_y;
    logic [COLOR_W-1:0]    s_line_color;

    assign s_func       = s_tuser[0];
    assign s_start_x    = s_tdata[12:0];
    assign s_start_y    = s_tdata[25:13];
    assign s_end_x      = s_tdata[38:26];
    assign s_end_y      = s_tdata[51:39];
    assign s_line_color = s_tdata[75:52];

    // Line setup arithmetic.
    logic [COORD_W-1:0] dx, dy, neg_dx, neg_dy;
    logic [MAG_W-1:0]   ax, ay, steps;

    always_comb begin
        dx     = {s_end_x[IN_COORD_W-1], s_end_x} - {s_start_x[IN_COORD_W-1], s_start_x};
        dy     = {s_end_y[IN_COORD_W-1], s_end_y} - {s_start_y[IN_COORD_W-1], s_start_y};
        neg_dx = -dx;
        neg_dy = -dy;
        ax     = dx[COORD_W-1] ? neg_dx[MAG_W-1:0] : dx[MAG_W-1:0];
        ay     = dy[COORD_W-1] ? neg_dy[MAG_W-1:0] : dy[MAG_W-1:0];
        steps  = (ax > ay) ? ax : ay;
    end

    // Line state.
    ddalr_state_t         state_reg, state_next;
    logic                 line_active_reg, line_active_next;
    logic [POINTS_W-1:0]  points_left_reg, points_left_next;
    logic [ACC_W-1:0]     acc_x_reg, acc_x_next;
    logic [ACC_W-1:0]     acc_y_reg, acc_y_next;
    logic [STEP_W-1:0]    step_x_reg, step_x_next;
    logic [STEP_W-1:0]    step_y_reg, step_y_next;
    logic [COLOR_W-1:0]   held_color_reg, held_color_next;
    logic                 sign_x_reg, sign_x_next;
    logic                 sign_y_reg, sign_y_next;
    logic [MAG_W-1:0]     ax_reg, ax_next;
    logic [MAG_W-1:0]     ay_reg, ay_next;
    logic [MAG_W-1:0]     steps_hold_reg, steps_hold_next;

    // Output register.
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 out_we_reg, out_we_next;
    logic [ADDR_W-1:0]    out_addr_reg, out_addr_next;
    logic [COLOR_W-1:0]   out_color_reg, out_color_next;
    logic                 out_last_reg, out_last_next;

    // Shared divider.
    logic                 div_start;
    logic [NUM_W-1:0]     div_numer;
    logic [NUM_W-1:0]     div_quot;
    ddalr_div_stat_t      div_stat;
    logic [STEP_W-1:0]    quot_ext, quot_neg;

    ddalr_div #(
        .NUM_W (NUM_W),
        .DEN_W (MAG_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (steps_hold_reg),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    assign quot_ext = {1'b0, div_quot[FRAC_BITS:0]};
    assign quot_neg = -quot_ext;

    // Point generation.
    logic               s_accept, begin_acc, tick_acc, tick_emit;
    logic [ACC_W-1:0]   acc_x_neg, acc_y_neg, mag_x_full, mag_y_full;
    logic [COORD_W-1:0] mag_x, mag_y;
    logic               neg_x, neg_y;
    logic [DIM_W-1:0]   eff_w, eff_h;
    logic               in_frame;
    logic [ADDR_W-1:0]  point_addr;
    logic               point_last;

    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_accept  = s_tvalid && s_tready;
    assign begin_acc = s_accept && (s_func == FUNC_BEGIN);
    assign tick_acc  = s_accept && (s_func == FUNC_TICK);
    assign tick_emit = tick_acc && line_active_reg;

    always_comb begin
        neg_x      = acc_x_reg[ACC_W-1];
        neg_y      = acc_y_reg[ACC_W-1];
        acc_x_neg  = -acc_x_reg;
        acc_y_neg  = -acc_y_reg;
        mag_x_full = neg_x ? acc_x_neg : acc_x_reg;
        mag_y_full = neg_y ? acc_y_neg : acc_y_reg;
        mag_x      = mag_x_full[FRAC_BITS +: COORD_W];
        mag_y      = mag_y_full[FRAC_BITS +: COORD_W];
        eff_w = (32'(frame_width_reg) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                       : DIM_W'(frame_width_reg);
        eff_h = (32'(frame_height_reg) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                        : DIM_W'(frame_height_reg);
        in_frame = (!neg_x || (mag_x == '0)) && (32'(mag_x) < 32'(eff_w))
                && (!neg_y || (mag_y == '0)) && (32'(mag_y) < 32'(eff_h));
        point_addr = in_frame ? (ADDR_W'(mag_x) + ADDR_W'(mag_y) * ADDR_W'(eff_w)) : '0;
        point_last = points_left_reg <= POINTS_W'(1);
    end

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        line_active_next = line_active_reg;
        points_left_next = points_left_reg;
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        held_color_next  = held_color_reg;
        sign_x_next      = sign_x_reg;
        sign_y_next      = sign_y_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        steps_hold_next  = steps_hold_reg;
        div_start        = 1'b0;
        div_numer        = {ax_reg, {FRAC_BITS{1'b0}}};

        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_we_next    = out_we_reg;
        out_addr_next  = out_addr_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (begin_acc) begin
                    acc_x_next       = {s_start_x[IN_COORD_W-1], s_start_x,
                                        {FRAC_BITS{1'b0}}};
                    acc_y_next       = {s_start_y[IN_COORD_W-1], s_start_y,
                                        {FRAC_BITS{1'b0}}};
                    points_left_next = POINTS_W'(steps) + POINTS_W'(1);
                    held_color_next  = s_line_color;
                    line_active_next = 1'b1;
                    sign_x_next      = dx[COORD_W-1];
                    sign_y_next      = dy[COORD_W-1];
                    ax_next          = ax;
                    ay_next          = ay;
                    steps_hold_next  = steps;
                    step_x_next      = '0;
                    step_y_next      = '0;
                    if (steps != '0) begin
                        state_next = ST_DIV_X;
                    end
                end else if (tick_emit) begin
                    m_tvalid_next  = 1'b1;
                    out_we_next    = in_frame;
                    out_addr_next  = point_addr;
                    out_color_next = held_color_reg;
                    out_last_next  = point_last;
                    acc_x_next = acc_x_reg + {{(ACC_W-STEP_W){step_x_reg[STEP_W-1]}},
                                              step_x_reg};
                    acc_y_next = acc_y_reg + {{(ACC_W-STEP_W){step_y_reg[STEP_W-1]}},
                                              step_y_reg};
                    if (point_last) begin
                        points_left_next = '0;
                        line_active_next = 1'b0;
                    end else begin
                        points_left_next = points_left_reg - POINTS_W'(1);
                    end
                end
            end
            ST_DIV_X: begin
                // The first cycle here launches the x division.
                if (!div_stat.busy && !div_stat.done) begin
                    div_start = 1'b1;
                end else if (div_stat.done) begin
                    step_x_next = sign_x_reg ? quot_neg : quot_ext;
                    state_next  = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                div_numer = {ay_reg, {FRAC_BITS{1'b0}}};
                if (!div_stat.busy && !div_stat.done) begin
                    div_start = 1'b1;
                end else if (div_stat.done) begin
                    step_y_next = sign_y_reg ? quot_neg : quot_ext;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            line_active_reg <= 1'b0;
            points_left_reg <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            step_x_reg      <= '0;
            step_y_reg      <= '0;
            held_color_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            line_active_reg <= line_active_next;
            points_left_reg <= points_left_next;
            acc_x_reg       <= acc_x_next;
            acc_y_reg       <= acc_y_next;
            step_x_reg      <= step_x_next;
            step_y_reg      <= step_y_next;
            held_color_reg  <= held_color_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        sign_x_reg     <= sign_x_next;
        sign_y_reg     <= sign_y_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        steps_hold_reg <= steps_hold_next;
        out_we_reg     <= out_we_next;
        out_addr_reg   <= out_addr_next;
        out_color_reg  <= out_color_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {{(M_TDATA_W-ADDR_W-COLOR_W){1'b0}}, out_color_reg, out_addr_reg};
    assign m_tuser[0] = out_we_reg;
    assign m_tlast    = out_last_reg;

    `ASSERT_IMP(a_no_accept_in_div, div_stat.busy || div_stat.done, !s_tready, "input in division")
    `ASSERT_IMP(a_div_only_in_setup, div_stat.busy, state_reg != ST_IDLE, "divider busy in idle")
    `ASSERT_NXT(a_tick_gives_result, tick_emit, m_tvalid, "tick gave no result")
    `ASSERT_NXT(a_last_ends_line, tick_emit && point_last, !line_active_reg, "line not ended")
    `ASSERT_IMP(a_clip_zero_addr, m_tvalid && !m_tuser[0], m_tdata[ADDR_W-1:0] == '0, "addr set")

endmodule

// ===== hw/rtl/ddalr_div.sv =====
module ddalr_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 13
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [NUM_W-1:0]           numer,
    input  logic [DEN_W-1:0]           denom,
    output logic [NUM_W-1:0]           quot,
    output ddalr_pkg::ddalr_div_stat_t stat
);
    import ddalr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    // One quotient bit per cycle, restoring division.
    always_comb begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_sub   = rem_shift - {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;

        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = numer;
            rem_next  = '0;
            den_next  = denom;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot      = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
